FILE: src/stm_pkg.sv
// shared types, codes and helpers for the sparse table range minimum engine
package stm_pkg;

  // query positions are always carried on ten bits
  localparam int unsigned POS_W  = 10;
  localparam int unsigned SPAN_W = POS_W + 1;
  localparam int unsigned LOG_W  = 4;

  // request codes
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_QB,
    ST_QOUT
  } stm_state_t;

  // memory port controls from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } stm_mem_ctl_t;

  // floor of log2 for a nonzero span
  function automatic logic [LOG_W-1:0] floor_log2(input logic [SPAN_W-1:0] x);
    logic [LOG_W-1:0] k;
    k = '0;
    for (int i = 1; i < SPAN_W; i++) begin
      if (x[i]) begin
        k = LOG_W'(i);
      end
    end
    return k;
  endfunction

endpackage

FILE: src/stm_table.sv
// window minimum table: one write port, one registered read port
module stm_table
  import stm_pkg::*;
#(
  parameter int unsigned AW          = 14,
  parameter int unsigned ENTRIES     = 11264,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  stm_mem_ctl_t                  mem_ctl,
  input  logic [AW-1:0]                 waddr,
  input  logic signed [VALUE_WIDTH-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic signed [VALUE_WIDTH-1:0] rdata
);

  logic [VALUE_WIDTH-1:0] mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/stm_ctrl.sv
// sequencer for appends, clears, window fills and range queries
module stm_ctrl
  import stm_pkg::*;
#(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned PW          = 10,
  parameter int unsigned LW          = 4,
  parameter int unsigned LEVELS      = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    mode,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic [POS_W-1:0]              left_pos,
  input  logic [POS_W-1:0]              right_pos,
  output logic                          busy,
  output logic                          strobe,
  output logic signed [VALUE_WIDTH-1:0] min_value,
  output logic                          error,
  output stm_mem_ctl_t                  mem_ctl,
  output logic [LW+PW-1:0]              waddr,
  output logic signed [VALUE_WIDTH-1:0] wdata,
  output logic [LW+PW-1:0]              raddr,
  input  logic signed [VALUE_WIDTH-1:0] rdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  stm_state_t state, state_next;

  logic [CW-1:0]                 count;
  logic [CW-1:0]                 np;
  logic [LW-1:0]                 lvl;
  logic signed [VALUE_WIDTH-1:0] prev;
  logic signed [VALUE_WIDTH-1:0] qa;
  logic [LW+PW-1:0]              qb_addr;
  logic                          qerr;

  logic                          accept;
  logic                          full;

  // query address arithmetic
  logic [POS_W-1:0]       lo;
  logic [POS_W-1:0]       hi;
  logic [SPAN_W-1:0]      span;
  logic [LOG_W-1:0]       qk4;
  logic [LW+LOG_W-1:0]    qk_wide;
  logic [LW-1:0]          qk;
  logic [SPAN_W-1:0]      b_start;
  logic [PW+SPAN_W-1:0]   b_wide;
  logic [PW+POS_W-1:0]    lo_wide;
  logic [CW+POS_W-1:0]    hi_cmp;
  logic [CW+POS_W-1:0]    cnt_cmp;
  logic                   q_err_in;

  // append and fill arithmetic
  logic [CW-1:0]          cm1;
  logic [CW-1:0]          s_cur;
  logic [LW:0]            lvl1;
  logic [CW-1:0]          len_next;
  logic [CW-1:0]          s_next;
  logic                   more;
  logic signed [VALUE_WIDTH-1:0] fill_min;
  logic signed [VALUE_WIDTH-1:0] q_min;

  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));

  // order the query positions, find the two windows and flag positions past the loaded count
  always_comb begin
    lo       = (left_pos > right_pos) ? right_pos : left_pos;
    hi       = (left_pos > right_pos) ? left_pos : right_pos;
    span     = {1'b0, hi} - {1'b0, lo} + SPAN_W'(1);
    qk4      = floor_log2(span);
    qk_wide  = {{LW{1'b0}}, qk4};
    qk       = qk_wide[LW-1:0];
    b_start  = {1'b0, hi} + SPAN_W'(1) - (SPAN_W'(1) << qk4);
    b_wide   = {{PW{1'b0}}, b_start};
    lo_wide  = {{PW{1'b0}}, lo};
    hi_cmp   = {{CW{1'b0}}, hi};
    cnt_cmp  = {{POS_W{1'b0}}, count};
    q_err_in = (hi_cmp >= cnt_cmp);
  end

  // window starts for the level being built and the next one
  always_comb begin
    cm1      = count - CW'(1);
    s_cur    = np - (CW'(1) << lvl);
    lvl1     = {1'b0, lvl} + (LW + 1)'(1);
    len_next = CW'(1) << lvl1;
    s_next   = np - len_next;
    more     = (lvl1 < (LW + 1)'(LEVELS)) && (len_next <= np);
    fill_min = (rdata < prev) ? rdata : prev;
    q_min    = (qa < rdata) ? qa : rdata;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_APPEND && !full && count != '0) begin
          state_next = ST_FILL;
        end else if (accept && mode == MODE_QUERY) begin
          state_next = ST_QB;
        end
      end
      ST_FILL: begin
        if (!more) begin
          state_next = ST_IDLE;
        end
      end
      ST_QB:   state_next = ST_QOUT;
      ST_QOUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port drive and busy
  always_comb begin
    mem_ctl = '0;
    waddr   = '0;
    wdata   = value;
    raddr   = '0;
    busy    = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept && mode == MODE_APPEND && !full) begin
          mem_ctl.wr_en = 1'b1;
          waddr         = {{LW{1'b0}}, count[PW-1:0]};
          wdata         = value;
          mem_ctl.rd_en = (count != '0);
          raddr         = {{LW{1'b0}}, cm1[PW-1:0]};
        end else if (accept && mode == MODE_QUERY) begin
          mem_ctl.rd_en = 1'b1;
          raddr         = {qk, lo_wide[PW-1:0]};
        end
      end
      ST_FILL: begin
        mem_ctl.wr_en = 1'b1;
        waddr         = {lvl, s_cur[PW-1:0]};
        wdata         = fill_min;
        mem_ctl.rd_en = more;
        raddr         = {lvl, s_next[PW-1:0]};
      end
      ST_QB: begin
        mem_ctl.rd_en = 1'b1;
        raddr         = qb_addr;
      end
      ST_QOUT: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_QOUT);
      if (state == ST_IDLE && accept && mode == MODE_CLEAR) begin
        count <= '0;
      end else if (state == ST_IDLE && accept && mode == MODE_APPEND && !full &&
                   count == '0) begin
        count <= CW'(1);
      end else if (state == ST_FILL && !more) begin
        count <= np;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        np      <= count + CW'(1);
        lvl     <= LW'(1);
        prev    <= value;
        qb_addr <= {qk, b_wide[PW-1:0]};
        qerr    <= q_err_in;
      end
      ST_FILL: begin
        prev <= fill_min;
        lvl  <= lvl1[LW-1:0];
      end
      ST_QB: begin
        qa <= rdata;
      end
      ST_QOUT: begin
        min_value <= qerr ? '0 : q_min;
        error     <= qerr;
      end
      default: begin
        qa <= qa;
      end
    endcase
  end

  // results never come in adjacent cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result strobe held for two cycles");

  // an out-of-range query reports zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && error |-> min_value == '0)
    else $error("flagged query carries a nonzero minimum");

  // every accepted query answers through states ST_QB and ST_QOUT and the strobe register
  a_query_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == MODE_QUERY |-> ##3 strobe)
    else $error("query result missing");

  // the loaded count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("loaded count beyond depth");

  // each fill step writes one window
  a_fill_writes: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> mem_ctl.wr_en)
    else $error("fill step without a table write");

endmodule

FILE: src/sparse_table_range_min.sv
// top level of the sparse table range minimum engine
//
// A request is taken on a rising edge with start high and busy low; mode picks
// append, range query or clear (mode 3 is ignored). An append stores value at
// the next position and then builds every power-of-two window ending there,
// one table level per cycle: the request cycle writes level 0 and each further
// cycle reads one window of the level below and writes one window, so an
// append holds busy until every window ending at its position is built.
// Appends to a full table and clears leave busy low. A query reads its two
// windows through the single read port of the table memory, one in the request
// cycle and one in state QB, and raises strobe for one cycle after the QOUT
// state, with min_value and error; positions at or beyond the loaded count set
// error and give a zero minimum. The receiver cannot hold results off. Reset
// empties the table (loaded count zero); the table memory itself is never
// swept, since only entries written since the last clear ever reach a result.
module sparse_table_range_min
  import stm_pkg::*;
#(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic [POS_W-1:0]              left_pos,
  input  logic [POS_W-1:0]              right_pos,
  output logic                          strobe,
  output logic signed [VALUE_WIDTH-1:0] min_value,
  output logic                          error
);

  localparam int unsigned PW      = $clog2(DEPTH);
  localparam int unsigned LEVELS  = $clog2(DEPTH + 1);
  localparam int unsigned LW      = $clog2(LEVELS);
  localparam int unsigned AW      = LW + PW;
  localparam int unsigned ENTRIES = LEVELS * (2 ** PW);

  stm_mem_ctl_t                  mem_ctl;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;
  logic signed [VALUE_WIDTH-1:0] wdata;
  logic signed [VALUE_WIDTH-1:0] rdata;

  // sequencer
  stm_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .PW          (PW),
    .LW          (LW),
    .LEVELS      (LEVELS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .value     (value),
    .left_pos  (left_pos),
    .right_pos (right_pos),
    .busy      (busy),
    .strobe    (strobe),
    .min_value (min_value),
    .error     (error),
    .mem_ctl   (mem_ctl),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  // window table memory
  stm_table #(
    .AW          (AW),
    .ENTRIES     (ENTRIES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_table (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the sparse table range minimum engine
module testbench
  import stm_pkg::*;
();

  localparam int unsigned TABLE_DEPTH    = 1024;
  localparam int unsigned TABLE_LEVELS   = 11;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [1:0]  MODE_UNUSED    = 2'd3;

  typedef struct {
    logic signed [31:0] min_value;
    logic               error;
  } range_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic [1:0]           mode      = MODE_APPEND;
  logic signed [31:0]   value     = '0;
  logic [POS_W-1:0]     left_pos  = '0;
  logic [POS_W-1:0]     right_pos = '0;
  logic                 busy;
  logic                 strobe;
  logic signed [31:0]   min_value;
  logic                 error;

  // model of the table contents and the results still to come
  logic signed [31:0]   window_min [TABLE_LEVELS][TABLE_DEPTH];
  int unsigned          element_count = 0;
  range_result_t        expected_minima [$];
  int unsigned          mismatch_count = 0;
  bit                   no_gaps = 1'b0;

  sparse_table_range_min #(
    .DEPTH      (TABLE_DEPTH),
    .VALUE_WIDTH(32)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .value    (value),
    .left_pos (left_pos),
    .right_pos(right_pos),
    .strobe   (strobe),
    .min_value(min_value),
    .error    (error)
  );

  always #10 clk = ~clk;

  function automatic logic signed [31:0] smaller(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  // append one element and complete every window that now ends at it
  function automatic void store_element(input logic signed [31:0] v);
    int unsigned p;
    int unsigned k;
    int unsigned s;
    p = element_count;
    if (p >= TABLE_DEPTH) begin
      return;
    end
    window_min[0][p] = v;
    for (k = 1; k < TABLE_LEVELS && (1 << k) <= p + 1; k++) begin
      s = p + 1 - (1 << k);
      window_min[k][s] = smaller(window_min[k-1][s], window_min[k-1][s + (1 << (k - 1))]);
    end
    element_count = p + 1;
  endfunction

  // minimum over two overlapping windows, or an error past the loaded count
  function automatic range_result_t predict_range_min(input int unsigned l,
                                                      input int unsigned r);
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   span;
    int unsigned   k;
    range_result_t res;
    lo = (l < r) ? l : r;
    hi = (l < r) ? r : l;
    if (hi >= element_count) begin
      res.min_value = '0;
      res.error     = 1'b1;
      return res;
    end
    span = hi - lo + 1;
    k = 0;
    while ((span >> (k + 1)) != 0) begin
      k++;
    end
    res.min_value = smaller(window_min[k][lo], window_min[k][hi + 1 - (1 << k)]);
    res.error     = 1'b0;
    return res;
  endfunction

  // mostly short gaps, a few long ones, none during a burst
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_gaps) begin
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(3, 1);
    end else if (roll < 97) begin
      return $urandom_range(12, 4);
    end else begin
      return $urandom_range(60, 20);
    end
  endfunction

  // element values with extra weight on the extremes and on ties
  function automatic logic signed [31:0] random_value();
    int unsigned roll;
    roll = $urandom_range(15);
    if (roll == 0) begin
      return {1'b1, 31'd0};
    end else if (roll == 1) begin
      return {1'b0, {31{1'b1}}};
    end else if (roll < 4) begin
      return $signed(32'($urandom_range(16))) - 32'sd8;
    end else begin
      return $urandom;
    end
  endfunction

  // drive one request, wait for it to be taken, then update the model
  task automatic send_request(input logic [1:0] req_mode, input logic signed [31:0] req_value,
                              input logic [POS_W-1:0] req_left,
                              input logic [POS_W-1:0] req_right);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    mode      <= req_mode;
    value     <= req_value;
    left_pos  <= req_left;
    right_pos <= req_right;
    do @(posedge clk); while (busy);
    case (req_mode)
      MODE_APPEND: store_element(req_value);
      MODE_QUERY:  expected_minima.push_back(predict_range_min(req_left, req_right));
      MODE_CLEAR:  element_count = 0;
      default: ;
    endcase
  endtask

  task automatic send_append();
    send_request(MODE_APPEND, random_value(), POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic send_noise();
    send_request(MODE_UNUSED, random_value(), POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic send_clear();
    send_request(MODE_CLEAR, random_value(), POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic send_query(input int unsigned l, input int unsigned r);
    send_request(MODE_QUERY, random_value(), POS_W'(l), POS_W'(r));
  endtask

  // mostly in-range queries, some short spans, some past the loaded count
  task automatic send_random_query();
    int unsigned n;
    int unsigned l;
    int unsigned r;
    int unsigned t;
    n = element_count;
    if (n == 0 || $urandom_range(9) == 0) begin
      l = $urandom_range(TABLE_DEPTH - 1);
      r = (n < TABLE_DEPTH) ? $urandom_range(TABLE_DEPTH - 1, n) : $urandom_range(TABLE_DEPTH - 1);
    end else begin
      l = $urandom_range(n - 1);
      if ($urandom_range(3) == 0) begin
        r = l + $urandom_range(3);
        if (r > n - 1) begin
          r = n - 1;
        end
      end else begin
        r = $urandom_range(n - 1);
      end
    end
    if ($urandom_range(1) == 1) begin
      t = l;
      l = r;
      r = t;
    end
    send_query(l, r);
  endtask

  // hold off requests until every pending result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (expected_minima.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // empty table, sign extremes, swapped positions, ignored mode, stale data after clear
  task automatic test_directed_cases();
    send_query(0, 0);
    send_query(TABLE_DEPTH - 1, TABLE_DEPTH - 1);
    send_clear();
    send_request(MODE_APPEND, {1'b0, {31{1'b1}}}, '0, '0);
    send_request(MODE_APPEND, {1'b1, 31'd0}, '0, '0);
    send_request(MODE_APPEND, -32'sd1, '0, '0);
    send_request(MODE_APPEND, 32'sd0, '0, '0);
    send_request(MODE_APPEND, 32'sd5, '0, '0);
    send_query(0, 0);
    send_query(1, 1);
    send_query(4, 0);
    send_query(2, 4);
    send_query(3, 4);
    send_query(0, 3);
    send_query(4, 5);
    send_request(MODE_UNUSED, 32'sd3, 10'd0, 10'd0);
    send_query(0, 4);
    send_clear();
    send_query(0, 0);
    send_request(MODE_APPEND, 32'sd7, '0, '0);
    send_request(MODE_APPEND, 32'sd9, '0, '0);
    send_request(MODE_APPEND, 32'sd8, '0, '0);
    send_query(0, 2);
    send_query(2, 1);
  endtask

  // several short loads, each followed by a batch of queries
  task automatic test_short_loads();
    int unsigned appends;
    repeat (4) begin
      no_gaps = ($urandom_range(2) == 0);
      if ($urandom_range(3) != 0) begin
        send_clear();
      end
      appends = $urandom_range(16, 1);
      repeat (appends) begin
        send_append();
        if ($urandom_range(3) == 0) begin
          send_random_query();
        end
        if ($urandom_range(39) == 0) begin
          send_noise();
        end
      end
      repeat ($urandom_range(12, 6)) send_random_query();
      drain_results();
    end
  endtask

  // grow the table to its full depth, then append past it and query the ends
  task automatic test_full_table();
    no_gaps = 1'b0;
    send_clear();
    while (element_count < TABLE_DEPTH) begin
      if (element_count % 128 == 0) begin
        no_gaps = ($urandom_range(2) == 0);
      end
      send_append();
      if ($urandom_range(31) == 0) begin
        send_random_query();
      end
      if ($urandom_range(127) == 0) begin
        send_noise();
      end
    end
    no_gaps = 1'b0;
    repeat (4) send_append();
    send_query(0, TABLE_DEPTH - 1);
    send_query(TABLE_DEPTH - 1, 0);
    send_query(TABLE_DEPTH - 1, TABLE_DEPTH - 1);
    send_query(0, 0);
    send_query(512, 511);
    repeat (8) send_random_query();
  endtask

  // compare each strobed result with the oldest pending query
  always @(posedge clk) begin : check_results
    range_result_t want;
    if (!rst && strobe === 1'b1) begin
      if (expected_minima.size() == 0) begin
        $display("%0t: unexpected result, min_value %0d error %0b", $time, min_value, error);
        mismatch_count++;
      end else begin
        want = expected_minima.pop_front();
        if (min_value !== want.min_value) begin
          $display("%0t: min_value expected %0d, got %0d", $time, want.min_value, min_value);
          mismatch_count++;
        end
        if (error !== want.error) begin
          $display("%0t: error expected %0b, got %0b", $time, want.error, error);
          mismatch_count++;
        end
      end
    end
  end

  // end the run if nothing moves for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || strobe === 1'b1) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: timeout, no request or result for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("sparse_table_range_min test failed");
    $finish;
  end

  // reset, run each test in turn, then wait out the last results
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    drain_results();
    test_short_loads();
    test_full_table();
    start <= 1'b0;
    while (expected_minima.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sparse_table_range_min test passed");
    end else begin
      $display("sparse_table_range_min test failed");
    end
    $finish;
  end

endmodule
